@@ rtl/bipartite_max_flow_defines.svh @@
// ----------------------------------------------------------------------------
// bipartite_max_flow_defines
// Assertion macros shared by the block's checking code.
// ----------------------------------------------------------------------------
`ifndef BIPARTITE_MAX_FLOW_DEFINES_SVH
`define BIPARTITE_MAX_FLOW_DEFINES_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmf assertion failed");

// next-cycle implication
`define BMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmf assertion failed");

`endif

@@ rtl/bmf_pkg.sv @@
// ----------------------------------------------------------------------------
// bmf_pkg
// Types and constants of the bipartite max-flow block.
// ----------------------------------------------------------------------------
package bmf_pkg;

   localparam int OUT_W = 23;
   localparam int MASK_W = 64;
   localparam int AMT_IN_W = 20;
   localparam logic [MASK_W-1:0] MASK_RESET = 64'd9277592187330931455;
   localparam logic REG_COMPAT = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic init;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic term_end;
      logic subset_end;
   } status_type;

endpackage

@@ rtl/bipartite_max_flow.sv @@
// ----------------------------------------------------------------------------
// bipartite_max_flow
// Supply/demand max flow under a compatibility mask, computed as min cut.
// ----------------------------------------------------------------------------
// Use:
//   Load items enter on start/busy with req_slot, req_amount, req_last; one
//   per cycle while busy is low. Slots below SUPPLY_CLASSES set a supply
//   amount, the next DEMAND_CLASSES slots a demand amount; amounts persist.
//   A transaction with req_last high starts the computation: busy stays high
//   while one cut term is summed per cycle by a single adder over every supply
//   subset. The last busy cycle carries the one-cycle rsp_valid strobe with
//   rsp_total_served; busy drops the cycle after. The receiver cannot stall;
//   the result is presented once.
//   compat_mask lives on the csr_ port at address 0. The user must write it
//   only while idle; the block itself does not enforce this.
//   Reset clears amounts, restores the default mask and returns to idle.
// ----------------------------------------------------------------------------
module bipartite_max_flow #(
   parameter int SUPPLY_CLASSES = 8,
   parameter int DEMAND_CLASSES = 8,
   parameter int AMOUNT_BITS    = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [3:0]                   req_slot,
   input  logic [bmf_pkg::AMT_IN_W-1:0] req_amount,
   input  logic                         req_last,
   output logic                         rsp_valid,
   output logic [bmf_pkg::OUT_W-1:0]    rsp_total_served,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic                         csr_paddr,
   input  logic [bmf_pkg::MASK_W-1:0]   csr_pwdata,
   output logic [bmf_pkg::MASK_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import bmf_pkg::*;
   `include "bipartite_max_flow_defines.svh"

   logic [MASK_W-1:0] mask_ff;
   logic              accept;
   cmd_type           cmd;
   status_type        status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_COMPAT) ? mask_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == REG_COMPAT) begin
         mask_ff <= csr_pwdata;
      end
   end

   assign accept = start && !busy;

   bmf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .go     (accept && req_last),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   bmf_dpath #(
      .SUPPLY_CLASSES (SUPPLY_CLASSES),
      .DEMAND_CLASSES (DEMAND_CLASSES),
      .AMOUNT_BITS    (AMOUNT_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .slot   (req_slot),
      .amount (req_amount),
      .mask   (mask_ff),
      .cmd    (cmd),
      .status (status),
      .total  (rsp_total_served)
   );

   `BMF_ASSERT_NEXT(a_last_goes_busy, clock, reset, accept && req_last, busy && !rsp_valid)
   `BMF_ASSERT_NEXT(a_idle_after_rsp, clock, reset, rsp_valid, !busy && !rsp_valid)
   `BMF_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)

endmodule

@@ rtl/bmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: starts a cut sweep on the last load, steps it, strobes result.
// ----------------------------------------------------------------------------
module bmf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  bmf_pkg::status_type status,
   output bmf_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                done
);
   import bmf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (go) begin
               cmd.init = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.term_end && status.subset_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/bmf_dpath.sv @@
// ----------------------------------------------------------------------------
// bmf_dpath
// Amount store and min-cut sweep: one cut term added per cycle, one
// supply subset per pass, running minimum kept as the result.
// ----------------------------------------------------------------------------
module bmf_dpath #(
   parameter int SUPPLY_CLASSES = 8,
   parameter int DEMAND_CLASSES = 8,
   parameter int AMOUNT_BITS    = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [3:0]                      slot,
   input  logic [bmf_pkg::AMT_IN_W-1:0]    amount,
   input  logic [bmf_pkg::MASK_W-1:0]      mask,
   input  bmf_pkg::cmd_type                cmd,
   output bmf_pkg::status_type             status,
   output logic [bmf_pkg::OUT_W-1:0]       total
);
   import bmf_pkg::*;

   localparam int TERMS = SUPPLY_CLASSES + DEMAND_CLASSES;
   localparam int TW    = $clog2(TERMS);
   localparam int SW    = $clog2(SUPPLY_CLASSES);
   localparam int DW    = $clog2(DEMAND_CLASSES);
   localparam int ACC_W = AMOUNT_BITS + 5;

   logic [AMOUNT_BITS-1:0]    supply_ff [SUPPLY_CLASSES];
   logic [AMOUNT_BITS-1:0]    demand_ff [DEMAND_CLASSES];
   logic [TW-1:0]             term_ff, term_in;
   logic [SUPPLY_CLASSES-1:0] subset_ff, subset_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [ACC_W-1:0]          best_ff, best_in;

   logic [SUPPLY_CLASSES-1:0] lnk [DEMAND_CLASSES];
   logic [DEMAND_CLASSES-1:0] nbr;
   logic [AMOUNT_BITS+AMT_IN_W-1:0] amt_ext;
   logic [AMOUNT_BITS-1:0]    amt;
   logic [4:0]                slot_w, dslot;
   logic                      is_supply_term;
   logic [TW-1:0]             dterm;
   logic [ACC_W-1:0]          addend, sum;
   logic [ACC_W+OUT_W-1:0]    best_ext;

   for (genvar s = 0; s < SUPPLY_CLASSES; s++) begin : g_s
      for (genvar d = 0; d < DEMAND_CLASSES; d++) begin : g_d
         if (s * DEMAND_CLASSES + d < MASK_W) begin : g_in
            assign lnk[d][s] = mask[s * DEMAND_CLASSES + d];
         end else begin : g_out
            assign lnk[d][s] = 1'b0;
         end
      end
   end

   always_comb begin
      for (int d = 0; d < DEMAND_CLASSES; d++) begin
         nbr[d] = |(lnk[d] & subset_ff);
      end
   end

   assign amt_ext = {{AMOUNT_BITS{1'b0}}, amount};
   assign amt     = amt_ext[AMOUNT_BITS-1:0];
   assign slot_w  = {1'b0, slot};
   assign dslot   = slot_w - 5'(SUPPLY_CLASSES);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SUPPLY_CLASSES; i++) begin
            supply_ff[i] <= '0;
         end
         for (int i = 0; i < DEMAND_CLASSES; i++) begin
            demand_ff[i] <= '0;
         end
      end else if (load) begin
         if (slot_w < 5'(SUPPLY_CLASSES)) begin
            supply_ff[slot[SW-1:0]] <= amt;
         end else if (dslot < 5'(DEMAND_CLASSES)) begin
            demand_ff[dslot[DW-1:0]] <= amt;
         end
      end
   end

   assign is_supply_term = term_ff < TW'(SUPPLY_CLASSES);
   assign dterm          = term_ff - TW'(SUPPLY_CLASSES);

   always_comb begin
      addend = '0;
      if (is_supply_term) begin
         if (!subset_ff[term_ff[SW-1:0]]) begin
            addend = ACC_W'(supply_ff[term_ff[SW-1:0]]);
         end
      end else if (nbr[dterm[DW-1:0]]) begin
         addend = ACC_W'(demand_ff[dterm[DW-1:0]]);
      end
   end

   assign sum               = acc_ff + addend;
   assign status.term_end   = term_ff == TW'(TERMS - 1);
   assign status.subset_end = &subset_ff;

   always_comb begin
      term_in   = term_ff;
      subset_in = subset_ff;
      acc_in    = acc_ff;
      best_in   = best_ff;
      priority if (cmd.init) begin
         term_in   = '0;
         subset_in = '0;
         acc_in    = '0;
         best_in   = '1;
      end else if (cmd.step) begin
         if (status.term_end) begin
            term_in   = '0;
            acc_in    = '0;
            subset_in = subset_ff + 1'b1;
            if (sum < best_ff) begin
               best_in = sum;
            end
         end else begin
            term_in = term_ff + 1'b1;
            acc_in  = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      term_ff   <= term_in;
      subset_ff <= subset_in;
      acc_ff    <= acc_in;
      best_ff   <= best_in;
   end

   assign best_ext = {{OUT_W{1'b0}}, best_ff};
   assign total    = best_ext[OUT_W-1:0];

endmodule
